// ===== rtl/mhpq_pkg.sv =====
package mhpq_pkg;

	localparam int MHPQ_CAPACITY = 64;
	localparam int PRI_W         = 16;
	localparam int PAY_W         = 32;
	localparam int STATUS_W      = 2;
	localparam int COUNT_W       = 7;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_REMOVED  = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [PAY_W-1:0] data;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_RM_RD,
		S_RM_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_OUT
	} state_t;

endpackage

// ===== rtl/mhpq_req_if.sv =====
interface mhpq_req_if
	import mhpq_pkg::*;
	();
	logic             valid;
	logic             ready;
	logic             cmd;
	logic [PRI_W-1:0] priority_req;
	logic [PAY_W-1:0] payload;

	modport source (output valid, cmd, priority_req, payload, input ready);
	modport sink (input valid, cmd, priority_req, payload, output ready);
endinterface

// ===== rtl/mhpq_rsp_if.sv =====
interface mhpq_rsp_if
	import mhpq_pkg::*;
	();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [PRI_W-1:0]    out_priority;
	logic [PAY_W-1:0]    out_payload;
	logic [COUNT_W-1:0]  count;

	modport source (output valid, status, out_priority, out_payload, count, input ready);
	modport sink (input valid, status, out_priority, out_payload, count, output ready);
endinterface

// ===== rtl/mhpq_ram.sv =====
module mhpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// Binary max-heap priority queue holding up to CAPACITY elements of a 16-bit
// signed priority and a 32-bit payload, kept in one dual-read-port RAM with an
// element count in flip-flops. One request is worked on at a time. An insert
// lets the new element climb level by level toward the root; a remove moves the
// last element to the root and lets it sink until it ends at a node with no
// children or below no larger child. Either walk covers at most log2(CAPACITY)
// levels. Full and empty rejections skip the walk and go straight to output.
// Each heap level takes a read state, set by the RAM's registered read, and a
// compare-and-write state. A new request is accepted while the previous result
// still waits in the output register.
module max_heap_priority_queue
	import mhpq_pkg::*;
#(
	parameter int CAPACITY = MHPQ_CAPACITY
) (
	input logic        clk,
	input logic        arst_n,
	mhpq_req_if.sink   req,
	mhpq_rsp_if.source rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int OW = $clog2(CAPACITY + 1);
	localparam int IW = OW + 1;
	localparam int EW = $bits(entry_t);

	state_t            state_q, state_d;
	logic [OW-1:0]     occ_q;
	logic [AW-1:0]     pos_q;
	logic [AW-1:0]     par_q;
	logic [AW-1:0]     lc_q;
	entry_t            cur_q;
	status_t           res_status_q;
	logic [PRI_W-1:0]  res_pri_q;
	logic [PAY_W-1:0]  res_pay_q;
	logic              out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [PRI_W-1:0]  out_pri_q;
	logic [PAY_W-1:0]  out_pay_q;
	logic [COUNT_W-1:0] out_count_q;

	logic              we;
	logic [AW-1:0]     waddr;
	entry_t            wdata;
	logic [AW-1:0]     raddr_a, raddr_b;
	logic [EW-1:0]     rdata_a_raw, rdata_b_raw;
	entry_t            rd_a, rd_b;

	logic              accept;
	logic              full, empty;
	logic              out_free;
	logic [AW-1:0]     parent;
	logic [IW-1:0]     lc;
	logic              rc_ok;
	logic              pick_r;
	entry_t            child;
	logic [AW-1:0]     child_idx;
	logic              up_move, dn_move;

	mhpq_ram #(
		.WIDTH(EW),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rdata_a_raw),
		.raddr_b (raddr_b),
		.rdata_b (rdata_b_raw)
	);

	assign rd_a = rdata_a_raw;
	assign rd_b = rdata_b_raw;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign full      = (occ_q >= OW'(CAPACITY));
	assign empty     = (occ_q == '0);
	assign out_free  = !out_valid_q || rsp.ready;

	assign parent    = (pos_q - AW'(1)) >> 1;
	assign lc        = IW'({pos_q, 1'b0}) + IW'(1);
	assign rc_ok     = (IW'(lc_q) + IW'(1)) < IW'(occ_q);
	assign pick_r    = rc_ok && ($signed(rd_b.pri) > $signed(rd_a.pri));
	assign child     = pick_r ? rd_b : rd_a;
	assign child_idx = pick_r ? (lc_q + AW'(1)) : lc_q;
	assign up_move   = $signed(cur_q.pri) > $signed(rd_a.pri);
	assign dn_move   = $signed(child.pri) > $signed(cur_q.pri);

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.out_priority = out_pri_q;
	assign rsp.out_payload  = out_pay_q;
	assign rsp.count        = out_count_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_INSERT) begin
						state_d = full ? S_OUT : S_UP_RD;
					end else begin
						state_d = empty ? S_OUT : S_RM_RD;
					end
				end
			end
			S_UP_RD: begin
				state_d = (pos_q == '0) ? S_OUT : S_UP_CMP;
			end
			S_UP_CMP: begin
				state_d = up_move ? S_UP_RD : S_OUT;
			end
			S_RM_RD: begin
				state_d = S_RM_LOAD;
			end
			S_RM_LOAD: begin
				state_d = S_DN_RD;
			end
			S_DN_RD: begin
				state_d = (lc >= IW'(occ_q)) ? S_OUT : S_DN_CMP;
			end
			S_DN_CMP: begin
				state_d = dn_move ? S_DN_RD : S_OUT;
			end
			S_OUT: begin
				state_d = out_free ? S_IDLE : S_OUT;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// memory access
	always_comb begin
		we      = 1'b0;
		waddr   = pos_q;
		wdata   = cur_q;
		raddr_a = '0;
		raddr_b = '0;
		case (state_q)
			S_UP_RD: begin
				raddr_a = parent;
				if (pos_q == '0) begin
					we = 1'b1;
				end
			end
			S_UP_CMP: begin
				we = 1'b1;
				if (up_move) begin
					wdata = rd_a;
				end
			end
			S_RM_RD: begin
				raddr_a = '0;
				raddr_b = AW'(occ_q);
			end
			S_DN_RD: begin
				raddr_a = lc[AW-1:0];
				raddr_b = lc[AW-1:0] + AW'(1);
				if (lc >= IW'(occ_q)) begin
					we = 1'b1;
				end
			end
			S_DN_CMP: begin
				we = 1'b1;
				if (dn_move) begin
					wdata = child;
				end
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (req.cmd == CMD_INSERT && !full) begin
					occ_q <= occ_q + OW'(1);
				end else if (req.cmd == CMD_REMOVE && !empty) begin
					occ_q <= occ_q - OW'(1);
				end
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cur_q     <= '{pri: req.priority_req, data: req.payload};
					pos_q     <= AW'(occ_q);
					res_pri_q <= '0;
					res_pay_q <= '0;
					if (req.cmd == CMD_INSERT) begin
						res_status_q <= full ? ST_FULL : ST_INSERTED;
					end else begin
						res_status_q <= empty ? ST_EMPTY : ST_REMOVED;
					end
				end
			end
			S_UP_RD: begin
				par_q <= parent;
			end
			S_UP_CMP: begin
				if (up_move) begin
					pos_q <= par_q;
				end
			end
			S_RM_LOAD: begin
				res_pri_q <= rd_a.pri;
				res_pay_q <= rd_a.data;
				cur_q     <= rd_b;
				pos_q     <= '0;
			end
			S_DN_RD: begin
				lc_q <= lc[AW-1:0];
			end
			S_DN_CMP: begin
				if (dn_move) begin
					pos_q <= child_idx;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_pri_q    <= res_pri_q;
					out_pay_q    <= res_pay_q;
					out_count_q  <= COUNT_W'(occ_q);
				end
			end
			default: begin
				pos_q <= pos_q;
			end
		endcase
	end

endmodule
